FILE: hw/rtl/plob_pkg.sv
// shared types, sizes and codes of the price level order book
package plob_pkg;

    // book sizes
    localparam int ORDER_SLOTS = 256;
    localparam int LEVEL_SLOTS = 64;

    // order table: one side bit above the slot index
    localparam int SLOT_IW = $clog2(ORDER_SLOTS);
    localparam int SLOT_AW = SLOT_IW + 1;
    localparam int SLOT_CW = SLOT_AW + 1;
    localparam int SLOT_DEPTH = 2 * ORDER_SLOTS;

    // level list: one side bit above the level index
    localparam int LVL_IW = $clog2(LEVEL_SLOTS);
    localparam int LVL_AW = LVL_IW + 1;
    localparam int LVL_CW = LVL_IW + 1;
    localparam int LVL_DEPTH = 2 * LEVEL_SLOTS;

    // field widths
    localparam int KEY_W = 32;
    localparam int PRICE_W = 32;
    localparam int QTY_W = 31;
    localparam int TOT_W = 48;
    localparam int CNT_W = 16;
    localparam int SLOT_W = 1 + KEY_W + PRICE_W + QTY_W;
    localparam int LVL_W = PRICE_W + TOT_W + CNT_W;

    // stream widths
    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 72;

    // opcodes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_MODIFY = 2'd2;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_NOT_FOUND  = 2'd1,
        STAT_ORDER_FULL = 2'd2,
        STAT_LEVEL_FULL = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SSCAN,
        S_SDEC,
        S_LSCAN,
        S_LDEC,
        S_LUPD,
        S_SHIFT,
        S_SHIFT_WR,
        S_DROP,
        S_DROP_WR,
        S_DONE
    } state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLEAR,
        DP_LOAD,
        DP_SSCAN,
        DP_LSTART,
        DP_LSCAN,
        DP_SLOT_WR,
        DP_LUPD,
        DP_SH_RD,
        DP_SH_WR,
        DP_INS,
        DP_DR_RD,
        DP_DR_WR,
        DP_DEC_N,
        DP_STATUS,
        DP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        status_t status;
    } dp_cmd_t;

    typedef struct packed {
        logic       clr_done;
        logic       sscan_done;
        logic       lscan_done;
        logic [1:0] opcode;
        logic       slot_found;
        logic       free_found;
        logic       lfound;
        logic       lvl_full;
        logic       sh_more;
        logic       dr_more;
        logic       drop;
        logic       out_free;
    } dp_stat_t;

endpackage

FILE: hw/rtl/plob_ram.sv
// generic single write, single read ram with registered read
module plob_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/plob_ctrl.sv
// sequencer for the order book operations
module plob_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  plob_pkg::dp_stat_t stat,
    output plob_pkg::dp_cmd_t  cmd
);
    import plob_pkg::*;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (stat.clr_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) state_next = S_SSCAN;
            end
            S_SSCAN: begin
                if (stat.sscan_done) state_next = S_SDEC;
            end
            S_SDEC: begin
                if (stat.opcode == OP_ADD) begin
                    state_next = (stat.slot_found || stat.free_found) ? S_LSCAN : S_DONE;
                end else if (stat.opcode == OP_CANCEL || stat.opcode == OP_MODIFY) begin
                    state_next = stat.slot_found ? S_LSCAN : S_DONE;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_LSCAN: begin
                if (stat.lscan_done) state_next = S_LDEC;
            end
            S_LDEC: begin
                if (stat.opcode == OP_ADD && !stat.lfound && stat.lvl_full) begin
                    state_next = S_DONE;
                end else if (stat.lfound) begin
                    state_next = S_LUPD;
                end else if (stat.opcode == OP_ADD) begin
                    state_next = S_SHIFT;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_LUPD: begin
                state_next = stat.drop ? S_DROP : S_DONE;
            end
            S_SHIFT: begin
                state_next = stat.sh_more ? S_SHIFT_WR : S_DONE;
            end
            S_SHIFT_WR: begin
                state_next = S_SHIFT;
            end
            S_DROP: begin
                state_next = stat.dr_more ? S_DROP_WR : S_DONE;
            end
            S_DROP_WR: begin
                state_next = S_DROP;
            end
            S_DONE: begin
                if (stat.out_free) state_next = S_IDLE;
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // commands to the datapath
    always_comb begin
        cmd.op = DP_NOP;
        cmd.status = STAT_OK;
        s_tready = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.op = DP_CLEAR;
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) cmd.op = DP_LOAD;
            end
            S_SSCAN: begin
                cmd.op = DP_SSCAN;
            end
            S_SDEC: begin
                if (stat.opcode == OP_ADD) begin
                    if (stat.slot_found || stat.free_found) begin
                        cmd.op = DP_LSTART;
                    end else begin
                        cmd.op = DP_STATUS;
                        cmd.status = STAT_ORDER_FULL;
                    end
                end else if (stat.opcode == OP_CANCEL || stat.opcode == OP_MODIFY) begin
                    if (stat.slot_found) begin
                        cmd.op = DP_LSTART;
                    end else begin
                        cmd.op = DP_STATUS;
                        cmd.status = STAT_NOT_FOUND;
                    end
                end else begin
                    cmd.op = DP_NOP;
                end
            end
            S_LSCAN: begin
                cmd.op = DP_LSCAN;
            end
            S_LDEC: begin
                if (stat.opcode == OP_ADD && !stat.lfound && stat.lvl_full) begin
                    cmd.op = DP_STATUS;
                    cmd.status = STAT_LEVEL_FULL;
                end else begin
                    cmd.op = DP_SLOT_WR;
                end
            end
            S_LUPD: begin
                cmd.op = DP_LUPD;
            end
            S_SHIFT: begin
                cmd.op = stat.sh_more ? DP_SH_RD : DP_INS;
            end
            S_SHIFT_WR: begin
                cmd.op = DP_SH_WR;
            end
            S_DROP: begin
                cmd.op = stat.dr_more ? DP_DR_RD : DP_DEC_N;
            end
            S_DROP_WR: begin
                cmd.op = DP_DR_WR;
            end
            S_DONE: begin
                if (stat.out_free) cmd.op = DP_OUT;
            end
            default: begin
                cmd.op = DP_NOP;
            end
        endcase
    end

endmodule

FILE: hw/rtl/plob_dp.sv
// order table, level lists, scan counters and result register
module plob_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  plob_pkg::dp_cmd_t               cmd,
    output plob_pkg::dp_stat_t              stat,
    input  logic [1:0]                      in_opcode,
    input  logic [plob_pkg::KEY_W-1:0]      in_key,
    input  logic                            in_side,
    input  logic [plob_pkg::PRICE_W-1:0]    in_price,
    input  logic [plob_pkg::QTY_W-1:0]      in_qty,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [plob_pkg::M_TDATA_W-1:0]  m_tdata
);
    import plob_pkg::*;

    localparam logic [SLOT_CW-1:0] SLOT_END = SLOT_CW'(SLOT_DEPTH);
    localparam logic [SLOT_CW-1:0] SLOT_LAST = SLOT_CW'(SLOT_DEPTH - 1);
    localparam logic [LVL_CW-1:0] LVL_MAX = LVL_CW'(LEVEL_SLOTS);
    localparam logic signed [TOT_W:0] TOT_HI = {2'b00, {(TOT_W-1){1'b1}}};
    localparam logic signed [TOT_W:0] TOT_LO = -TOT_HI;

    // operation registers
    logic [1:0]         op_reg, op_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic               side_reg, side_next;
    logic [PRICE_W-1:0] price_reg, price_next;
    logic [QTY_W-1:0]   qty_reg, qty_next;

    // order table scan
    logic [SLOT_CW-1:0] sidx_reg, sidx_next;
    logic               srd_vld_reg, srd_vld_next;
    logic [SLOT_AW-1:0] srd_addr_reg, srd_addr_next;
    logic               found_reg, found_next;
    logic [SLOT_AW-1:0] maddr_reg, maddr_next;
    logic [PRICE_W-1:0] mprice_reg, mprice_next;
    logic [QTY_W-1:0]   mqty_reg, mqty_next;
    logic               free_reg, free_next;
    logic [SLOT_AW-1:0] faddr_reg, faddr_next;

    // level list scan and edit
    logic               wside_reg, wside_next;
    logic [PRICE_W-1:0] wprice_reg, wprice_next;
    logic [LVL_CW-1:0]  lscan_reg, lscan_next;
    logic               lrd_vld_reg, lrd_vld_next;
    logic [LVL_CW-1:0]  lrd_idx_reg, lrd_idx_next;
    logic               lfound_reg, lfound_next;
    logic [LVL_CW-1:0]  lidx_reg, lidx_next;
    logic signed [TOT_W-1:0] ltot_reg, ltot_next;
    logic [CNT_W-1:0]   lcnt_reg, lcnt_next;
    logic               pfound_reg, pfound_next;
    logic [LVL_CW-1:0]  pos_reg, pos_next;
    logic [LVL_CW-1:0]  lptr_reg, lptr_next;
    logic [LVL_CW-1:0]  n_reg [2];
    logic [LVL_CW-1:0]  n_next [2];
    logic [PRICE_W-1:0] best_reg [2];
    logic [PRICE_W-1:0] best_next [2];

    // result
    status_t               status_reg, status_next;
    logic                  mvalid_reg, mvalid_next;
    logic [M_TDATA_W-1:0]  mdata_reg, mdata_next;

    // memory ports
    logic               s_we;
    logic [SLOT_AW-1:0] s_waddr, s_raddr;
    logic [SLOT_W-1:0]  s_wdata, s_rdata;
    logic               l_we;
    logic [LVL_AW-1:0]  l_waddr, l_raddr;
    logic [LVL_W-1:0]   l_wdata, l_rdata;

    // decoded read words
    logic               e_valid;
    logic [KEY_W-1:0]   e_key;
    logic [PRICE_W-1:0] e_price;
    logic [QTY_W-1:0]   e_qty;
    logic [PRICE_W-1:0] lv_price;
    logic [TOT_W-1:0]   lv_tot;
    logic [CNT_W-1:0]   lv_cnt;

    logic               is_add;
    logic [LVL_CW-1:0]  n_cur;
    logic [LVL_CW-1:0]  pos_eff;
    logic signed [QTY_W+1:0] delta;
    logic signed [TOT_W:0]   sum;
    logic signed [TOT_W-1:0] new_tot;
    logic [CNT_W-1:0]   new_cnt;

    plob_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_DEPTH)) u_slot_ram (
        .aclk  (aclk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    plob_ram #(.WIDTH(LVL_W), .DEPTH(LVL_DEPTH)) u_level_ram (
        .aclk  (aclk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    assign {e_valid, e_key, e_price, e_qty} = s_rdata;
    assign {lv_price, lv_tot, lv_cnt} = l_rdata;
    assign is_add = (op_reg == OP_ADD);
    assign n_cur = n_reg[wside_reg];
    assign pos_eff = pfound_reg ? pos_reg : n_cur;

    // level total update with saturation
    always_comb begin
        if (op_reg == OP_ADD) begin
            delta = $signed({2'b00, qty_reg});
            new_cnt = lcnt_reg + CNT_W'(1);
        end else if (op_reg == OP_CANCEL) begin
            delta = -$signed({2'b00, mqty_reg});
            new_cnt = lcnt_reg - CNT_W'(1);
        end else begin
            delta = $signed({2'b00, qty_reg}) - $signed({2'b00, mqty_reg});
            new_cnt = lcnt_reg;
        end
        sum = $signed({ltot_reg[TOT_W-1], ltot_reg})
            + $signed({{(TOT_W-QTY_W-1){delta[QTY_W+1]}}, delta});
        if (sum > TOT_HI) begin
            new_tot = TOT_HI[TOT_W-1:0];
        end else if (sum < TOT_LO) begin
            new_tot = TOT_LO[TOT_W-1:0];
        end else begin
            new_tot = sum[TOT_W-1:0];
        end
    end

    // status to the controller
    always_comb begin
        stat.clr_done = (sidx_reg == SLOT_LAST);
        stat.sscan_done = (sidx_reg == SLOT_END) && !srd_vld_reg;
        stat.lscan_done = (lscan_reg == n_cur) && !lrd_vld_reg;
        stat.opcode = op_reg;
        stat.slot_found = found_reg;
        stat.free_found = free_reg;
        stat.lfound = lfound_reg;
        stat.lvl_full = (n_cur == LVL_MAX);
        stat.sh_more = (lptr_reg > pos_eff);
        stat.dr_more = ((lptr_reg + LVL_CW'(1)) < n_cur);
        stat.drop = (op_reg == OP_CANCEL) && (new_tot <= 0);
        stat.out_free = !mvalid_reg || m_tready;
    end

    // datapath next values and memory ports
    always_comb begin
        op_next = op_reg;
        key_next = key_reg;
        side_next = side_reg;
        price_next = price_reg;
        qty_next = qty_reg;
        sidx_next = sidx_reg;
        srd_vld_next = 1'b0;
        srd_addr_next = srd_addr_reg;
        found_next = found_reg;
        maddr_next = maddr_reg;
        mprice_next = mprice_reg;
        mqty_next = mqty_reg;
        free_next = free_reg;
        faddr_next = faddr_reg;
        wside_next = wside_reg;
        wprice_next = wprice_reg;
        lscan_next = lscan_reg;
        lrd_vld_next = 1'b0;
        lrd_idx_next = lrd_idx_reg;
        lfound_next = lfound_reg;
        lidx_next = lidx_reg;
        ltot_next = ltot_reg;
        lcnt_next = lcnt_reg;
        pfound_next = pfound_reg;
        pos_next = pos_reg;
        lptr_next = lptr_reg;
        n_next = n_reg;
        best_next = best_reg;
        status_next = status_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mdata_next = mdata_reg;

        s_we = 1'b0;
        s_waddr = sidx_reg[SLOT_AW-1:0];
        s_wdata = '0;
        s_raddr = sidx_reg[SLOT_AW-1:0];
        l_we = 1'b0;
        l_waddr = {wside_reg, lptr_reg[LVL_IW-1:0]};
        l_wdata = l_rdata;
        l_raddr = {wside_reg, lscan_reg[LVL_IW-1:0]};

        // evaluate the order word read last cycle
        if (srd_vld_reg) begin
            if (e_valid && e_key == key_reg && !found_reg
                && (!is_add || srd_addr_reg[SLOT_AW-1] == side_reg)) begin
                found_next = 1'b1;
                maddr_next = srd_addr_reg;
                mprice_next = e_price;
                mqty_next = e_qty;
            end
            if (!e_valid && !free_reg && srd_addr_reg[SLOT_AW-1] == side_reg) begin
                free_next = 1'b1;
                faddr_next = srd_addr_reg;
            end
        end

        // evaluate the level word read last cycle
        if (lrd_vld_reg) begin
            if (lv_price == wprice_reg && !lfound_reg) begin
                lfound_next = 1'b1;
                lidx_next = lrd_idx_reg;
                ltot_next = $signed(lv_tot);
                lcnt_next = lv_cnt;
            end
            if (is_add && !pfound_reg
                && (wside_reg ? (lv_price > wprice_reg) : (lv_price < wprice_reg))) begin
                pfound_next = 1'b1;
                pos_next = lrd_idx_reg;
            end
        end

        case (cmd.op)
            DP_CLEAR: begin
                s_we = 1'b1;
                s_wdata = '0;
                sidx_next = sidx_reg + SLOT_CW'(1);
            end
            DP_LOAD: begin
                op_next = in_opcode;
                key_next = in_key;
                side_next = in_side;
                price_next = in_price;
                qty_next = in_qty;
                sidx_next = '0;
                found_next = 1'b0;
                free_next = 1'b0;
                status_next = STAT_OK;
            end
            DP_SSCAN: begin
                if (sidx_reg != SLOT_END) begin
                    sidx_next = sidx_reg + SLOT_CW'(1);
                    srd_vld_next = 1'b1;
                    srd_addr_next = sidx_reg[SLOT_AW-1:0];
                end
            end
            DP_LSTART: begin
                wside_next = is_add ? side_reg : maddr_reg[SLOT_AW-1];
                wprice_next = is_add ? price_reg : mprice_reg;
                lscan_next = '0;
                lfound_next = 1'b0;
                pfound_next = 1'b0;
            end
            DP_LSCAN: begin
                if (lscan_reg != n_cur) begin
                    lscan_next = lscan_reg + LVL_CW'(1);
                    lrd_vld_next = 1'b1;
                    lrd_idx_next = lscan_reg;
                end
            end
            DP_SLOT_WR: begin
                s_we = 1'b1;
                if (is_add) begin
                    s_waddr = found_reg ? maddr_reg : faddr_reg;
                    s_wdata = {1'b1, key_reg, price_reg, qty_reg};
                    lptr_next = n_cur;
                end else if (op_reg == OP_CANCEL) begin
                    s_waddr = maddr_reg;
                    s_wdata = {1'b0, key_reg, mprice_reg, mqty_reg};
                    lptr_next = lidx_reg;
                end else begin
                    s_waddr = maddr_reg;
                    s_wdata = {1'b1, key_reg, mprice_reg, qty_reg};
                    lptr_next = lidx_reg;
                end
            end
            DP_LUPD: begin
                l_we = 1'b1;
                l_waddr = {wside_reg, lidx_reg[LVL_IW-1:0]};
                l_wdata = {wprice_reg, new_tot, new_cnt};
            end
            DP_SH_RD: begin
                l_raddr = {wside_reg, lptr_next[LVL_IW-1:0] - LVL_IW'(1)};
            end
            DP_SH_WR: begin
                l_we = 1'b1;
                l_waddr = {wside_reg, lptr_reg[LVL_IW-1:0]};
                l_wdata = l_rdata;
                lptr_next = lptr_reg - LVL_CW'(1);
            end
            DP_INS: begin
                l_we = 1'b1;
                l_waddr = {wside_reg, pos_eff[LVL_IW-1:0]};
                l_wdata = {wprice_reg, {(TOT_W-QTY_W){1'b0}}, qty_reg, CNT_W'(1)};
                n_next[wside_reg] = n_cur + LVL_CW'(1);
            end
            DP_DR_RD: begin
                l_raddr = {wside_reg, lptr_reg[LVL_IW-1:0] + LVL_IW'(1)};
            end
            DP_DR_WR: begin
                l_we = 1'b1;
                l_waddr = {wside_reg, lptr_reg[LVL_IW-1:0]};
                l_wdata = l_rdata;
                lptr_next = lptr_reg + LVL_CW'(1);
            end
            DP_DEC_N: begin
                n_next[wside_reg] = n_cur - LVL_CW'(1);
            end
            DP_STATUS: begin
                status_next = cmd.status;
            end
            DP_OUT: begin
                mvalid_next = 1'b1;
                mdata_next = {6'd0,
                              (n_reg[1] != '0) ? best_reg[1] : PRICE_W'(0),
                              (n_reg[0] != '0) ? best_reg[0] : PRICE_W'(0),
                              status_reg};
            end
            default: begin
                s_we = 1'b0;
            end
        endcase

        // keep the head price of each list at hand
        if (l_we && l_waddr[LVL_IW-1:0] == '0) begin
            best_next[l_waddr[LVL_AW-1]] = l_wdata[LVL_W-1 -: PRICE_W];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sidx_reg <= '0;
            srd_vld_reg <= 1'b0;
            lrd_vld_reg <= 1'b0;
            n_reg[0] <= '0;
            n_reg[1] <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            sidx_reg <= sidx_next;
            srd_vld_reg <= srd_vld_next;
            lrd_vld_reg <= lrd_vld_next;
            n_reg <= n_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg <= op_next;
        key_reg <= key_next;
        side_reg <= side_next;
        price_reg <= price_next;
        qty_reg <= qty_next;
        srd_addr_reg <= srd_addr_next;
        found_reg <= found_next;
        maddr_reg <= maddr_next;
        mprice_reg <= mprice_next;
        mqty_reg <= mqty_next;
        free_reg <= free_next;
        faddr_reg <= faddr_next;
        wside_reg <= wside_next;
        wprice_reg <= wprice_next;
        lscan_reg <= lscan_next;
        lrd_idx_reg <= lrd_idx_next;
        lfound_reg <= lfound_next;
        lidx_reg <= lidx_next;
        ltot_reg <= ltot_next;
        lcnt_reg <= lcnt_next;
        pfound_reg <= pfound_next;
        pos_reg <= pos_next;
        lptr_reg <= lptr_next;
        best_reg <= best_next;
        status_reg <= status_next;
        mdata_reg <= mdata_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata = mdata_reg;

endmodule

FILE: hw/rtl/price_level_order_book_unit.sv
// top level of the price level order book
// each word runs a scan of the order table memory, one entry per cycle, then a scan of
// the level list, then a shift of the level list to insert a new price or to drop an
// emptied level; the next word is taken while a result waits in the output register
// reset: synchronous active-low; afterwards a clearing pass over the whole order table
// runs with s_tready low
module price_level_order_book_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // order_key[31:0], price[63:32], quantity[94:64], zero pad
    input  logic [plob_pkg::S_TDATA_W-1:0]    s_tdata,
    // opcode[1:0], side[2]
    input  logic [plob_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status[1:0], top bid price[33:2], top ask price[65:34], zero pad
    output logic [plob_pkg::M_TDATA_W-1:0]    m_tdata
);
    import plob_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    plob_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    plob_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_opcode (s_tuser[1:0]),
        .in_key    (s_tdata[31:0]),
        .in_side   (s_tuser[2]),
        .in_price  (s_tdata[63:32]),
        .in_qty    (s_tdata[94:64]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: dv/tb_top.sv
// self-checking testbench for the price level order book unit
`timescale 1ns / 100ps

import plob_pkg::*;

typedef struct {
    logic [1:0]  status;
    logic [31:0] bid_top;
    logic [31:0] ask_top;
} book_result_t;

// book shadow: predicts status and best prices, holds expected words
class book_scoreboard;
    logic        ord_valid [2][ORDER_SLOTS];
    logic [31:0] ord_key [2][ORDER_SLOTS];
    logic [31:0] ord_price [2][ORDER_SLOTS];
    logic [30:0] ord_qty [2][ORDER_SLOTS];
    logic [31:0] lvl_price [2][LEVEL_SLOTS];
    longint      lvl_total [2][LEVEL_SLOTS];
    logic [15:0] lvl_count [2][LEVEL_SLOTS];
    int          lvl_used [2];
    book_result_t pending_results[$];
    int          mismatches;

    function new();
        for (int s = 0; s < 2; s++) begin
            lvl_used[s] = 0;
            for (int i = 0; i < ORDER_SLOTS; i++) ord_valid[s][i] = 1'b0;
        end
        mismatches = 0;
    endfunction

    function longint clip_total(longint v);
        longint lim;
        lim = 64'h7FFF_FFFF_FFFF;
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function int slot_of(int s, logic [31:0] key);
        for (int i = 0; i < ORDER_SLOTS; i++)
            if (ord_valid[s][i] && ord_key[s][i] == key) return i;
        return -1;
    endfunction

    function int level_of(int s, logic [31:0] price);
        for (int i = 0; i < lvl_used[s]; i++)
            if (lvl_price[s][i] == price) return i;
        return -1;
    endfunction

    function logic [1:0] place_order(int s, logic [31:0] key, logic [31:0] price,
                                     logic [30:0] qty);
        int slot;
        int lv;
        int pos;
        slot = slot_of(s, key);
        if (slot < 0) begin
            for (int i = ORDER_SLOTS - 1; i >= 0; i--)
                if (!ord_valid[s][i]) slot = i;
            if (slot < 0) return STAT_ORDER_FULL;
        end
        lv = level_of(s, price);
        if (lv < 0 && lvl_used[s] >= LEVEL_SLOTS) return STAT_LEVEL_FULL;
        ord_valid[s][slot] = 1'b1;
        ord_key[s][slot] = key;
        ord_price[s][slot] = price;
        ord_qty[s][slot] = qty;
        if (lv >= 0) begin
            lvl_total[s][lv] = clip_total(lvl_total[s][lv] + longint'(qty));
            lvl_count[s][lv] = lvl_count[s][lv] + 16'd1;
        end else begin
            pos = 0;
            while (pos < lvl_used[s] &&
                   !(s == 0 ? lvl_price[s][pos] < price : lvl_price[s][pos] > price))
                pos++;
            for (int i = lvl_used[s]; i > pos; i--) begin
                lvl_price[s][i] = lvl_price[s][i-1];
                lvl_total[s][i] = lvl_total[s][i-1];
                lvl_count[s][i] = lvl_count[s][i-1];
            end
            lvl_price[s][pos] = price;
            lvl_total[s][pos] = longint'(qty);
            lvl_count[s][pos] = 16'd1;
            lvl_used[s]++;
        end
        return STAT_OK;
    endfunction

    function logic [1:0] cancel_or_modify(logic is_cancel, logic [31:0] key,
                                          logic [30:0] qty);
        int slot;
        int lv;
        for (int s = 0; s < 2; s++) begin
            slot = slot_of(s, key);
            if (slot >= 0) begin
                lv = level_of(s, ord_price[s][slot]);
                if (is_cancel) begin
                    if (lv >= 0) begin
                        lvl_total[s][lv] = clip_total(lvl_total[s][lv]
                                                      - longint'(ord_qty[s][slot]));
                        lvl_count[s][lv] = lvl_count[s][lv] - 16'd1;
                        if (lvl_total[s][lv] <= 0) begin
                            for (int i = lv; i + 1 < lvl_used[s]; i++) begin
                                lvl_price[s][i] = lvl_price[s][i+1];
                                lvl_total[s][i] = lvl_total[s][i+1];
                                lvl_count[s][i] = lvl_count[s][i+1];
                            end
                            lvl_used[s]--;
                        end
                    end
                    ord_valid[s][slot] = 1'b0;
                end else begin
                    if (lv >= 0)
                        lvl_total[s][lv] = clip_total(lvl_total[s][lv]
                            - longint'(ord_qty[s][slot]) + longint'(qty));
                    ord_qty[s][slot] = qty;
                end
                return STAT_OK;
            end
        end
        return STAT_NOT_FOUND;
    endfunction

    // note an accepted input word and queue its expected result
    function void note_order(logic [1:0] op, logic [31:0] key, logic side,
                             logic [31:0] price, logic [30:0] qty);
        book_result_t r;
        r.status = STAT_OK;
        case (op)
            OP_ADD:    r.status = place_order(side, key, price, qty);
            OP_CANCEL: r.status = cancel_or_modify(1'b1, key, qty);
            OP_MODIFY: r.status = cancel_or_modify(1'b0, key, qty);
            default:   r.status = STAT_OK;
        endcase
        r.bid_top = lvl_used[0] > 0 ? lvl_price[0][0] : 32'd0;
        r.ask_top = lvl_used[1] > 0 ? lvl_price[1][0] : 32'd0;
        pending_results.insert(pending_results.size(), r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // compare an accepted result word with the oldest expectation
    task check_result(logic [M_TDATA_W-1:0] word);
        book_result_t e;
        if (pending_results.size() == 0) begin
            report("unexpected word", word[31:0], 32'd0);
            return;
        end
        e = pending_results.pop_front();
        if (word[1:0] !== e.status) report("status", 32'(word[1:0]), 32'(e.status));
        if (word[33:2] !== e.bid_top) report("bid_top", word[33:2], e.bid_top);
        if (word[65:34] !== e.ask_top) report("ask_top", word[65:34], e.ask_top);
        if (word[71:66] !== 6'd0) report("pad", 32'(word[71:66]), 32'd0);
    endtask
endclass

module tb_top;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [1:0] OP_NONE = 2'd3;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    book_scoreboard sb;
    int idle_cycles = 0;
    int words_sent;
    int words_checked;
    logic [31:0] key_pool[$];
    logic [31:0] price_pool [2][8];

    price_level_order_book_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // clock
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // result side: random stalls and checking
    initial begin
        int gap;
        m_tready = 1'b0;
        sb = new();
        words_checked = 0;
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            sb.check_result(m_tdata);
            words_checked++;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // send one word and note it once accepted
    task send_order(logic [1:0] op, logic [31:0] key, logic side, logic [31:0] price,
                    logic [30:0] qty, bit gaps);
        int gap;
        gap = (gaps && $urandom_range(0, 3) != 0) ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= {side, op};
        s_tdata <= {1'b0, qty, price, key};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_order(op, key, side, price, qty);
        words_sent++;
    endtask

    task wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_results.size() != 0) @(posedge aclk);
    endtask

    function logic [31:0] pick_key();
        if (key_pool.size() == 0 || $urandom_range(0, 9) == 0) return $urandom;
        return key_pool[$urandom_range(0, key_pool.size() - 1)];
    endfunction

    initial begin
        logic [31:0] k;
        logic [31:0] p;
        logic [30:0] q;
        logic [1:0] op;
        logic sd;
        int r;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        words_sent = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, every op, missing keys, unused opcode
        send_order(OP_CANCEL, 32'h1234, 1'b0, 32'd0, 31'd5, 1'b0);
        send_order(OP_MODIFY, 32'hFFFF_FFFF, 1'b1, 32'd0, 31'd5, 1'b0);
        send_order(OP_NONE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b0);
        send_order(OP_ADD, 32'd0, 1'b0, 32'd0, 31'd0, 1'b1);
        send_order(OP_ADD, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1);
        send_order(OP_ADD, 32'd7, 1'b1, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1);
        send_order(OP_ADD, 32'd8, 1'b1, 32'd1, 31'd10, 1'b1);
        send_order(OP_ADD, 32'd9, 1'b1, 32'd1, 31'd20, 1'b1);
        send_order(OP_ADD, 32'd8, 1'b1, 32'd1, 31'd3, 1'b1);
        send_order(OP_MODIFY, 32'd9, 1'b0, 32'd0, 31'd0, 1'b1);
        send_order(OP_CANCEL, 32'd8, 1'b0, 32'd0, 31'd0, 1'b1);
        send_order(OP_MODIFY, 32'hFFFF_FFFF, 1'b0, 32'd0, 31'd1, 1'b1);
        send_order(OP_CANCEL, 32'd0, 1'b0, 32'd0, 31'd0, 1'b1);
        send_order(OP_CANCEL, 32'd9, 1'b0, 32'd0, 31'd0, 1'b1);
        send_order(OP_ADD, 32'd8, 1'b0, 32'h5555_5555, 31'h2AAA_AAAA, 1'b1);
        send_order(OP_ADD, 32'd8, 1'b1, 32'hAAAA_AAAA, 31'h5555_5555, 1'b1);
        send_order(OP_CANCEL, 32'd8, 1'b0, 32'd0, 31'd0, 1'b1);
        send_order(OP_CANCEL, 32'd8, 1'b0, 32'd0, 31'd0, 1'b1);
        wait_drained();

        // level list full on the ask side, then order table full on the bid side
        for (int i = 0; i < LEVEL_SLOTS + 1; i++)
            send_order(OP_ADD, 32'h1000_0000 + i, 1'b1, 32'd100 + i * 3, 31'd1,
                       i % 8 == 0);
        for (int i = 0; i < ORDER_SLOTS + 1; i++)
            send_order(OP_ADD, 32'h2000_0000 + i, 1'b0, 32'd50 + i % 4, 31'd2,
                       i % 16 == 0);
        for (int i = 0; i < ORDER_SLOTS; i++)
            send_order(OP_CANCEL, 32'h2000_0000 + i, 1'b0, 32'd0, 31'd0, i % 16 == 0);
        for (int i = 0; i < LEVEL_SLOTS; i++)
            send_order(OP_CANCEL, 32'h1000_0000 + i, 1'b0, 32'd0, 31'd0, i % 8 == 0);
        wait_drained();

        // random: mostly keys drawn from a pool of earlier added keys and prices from a small pool
        for (int s = 0; s < 2; s++)
            for (int i = 0; i < 8; i++) price_pool[s][i] = $urandom;
        for (int n = 0; n < 290; n++) begin
            r = $urandom_range(0, 99);
            op = r < 45 ? OP_ADD : (r < 75 ? OP_CANCEL : (r < 97 ? OP_MODIFY : OP_NONE));
            sd = $urandom_range(0, 1);
            k = (op == OP_ADD && $urandom_range(0, 2) != 0) ? $urandom : pick_key();
            if (op == OP_ADD && key_pool.size() < 64) key_pool.insert(key_pool.size(), k);
            p = $urandom_range(0, 4) == 0 ? $urandom : price_pool[sd][$urandom_range(0, 7)];
            q = $urandom_range(0, 9) == 0 ? 31'({$urandom}) : 31'($urandom_range(0, 1000));
            send_order(op, k, sd, p, q, n % 100 < 75);
            if (n == 150) wait_drained();
        end

        wait_drained();
        repeat (700) @(posedge aclk);
        $display("sent %0d words, checked %0d results, mismatches %0d",
                 words_sent, words_checked, sb.mismatches);
        $display("covered all ops, missing keys, full tables and random book traffic");
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
